### sv/obte_pkg.sv
`default_nettype none
package obte_pkg;

  // Operation kinds of an input item
  localparam logic [2:0] KIND_ADD     = 3'd0;
  localparam logic [2:0] KIND_CANCEL  = 3'd1;
  localparam logic [2:0] KIND_REDUCE  = 3'd2;
  localparam logic [2:0] KIND_REPLACE = 3'd3;
  localparam logic [2:0] KIND_DUMP    = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_DUMP      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  // Write data / address selection
  localparam logic [1:0] WR_NEW   = 2'd0;
  localparam logic [1:0] WR_UPD   = 2'd1;
  localparam logic [1:0] WR_SHIFT = 2'd2;

  // Result payload source
  localparam logic [2:0] OSRC_NEW  = 3'd0;
  localparam logic [2:0] OSRC_RD   = 3'd1;
  localparam logic [2:0] OSRC_MOD  = 3'd2;
  localparam logic [2:0] OSRC_ID   = 3'd3;
  localparam logic [2:0] OSRC_ZERO = 3'd4;

  localparam logic signed [31:0] QTY_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [31:0]        id;
    logic               side;
    logic signed [31:0] qty;
    logic [31:0]        price;
  } entry_t;

  typedef struct packed {
    logic       ld_in;
    logic       rd_en;
    logic       idx_top;
    logic       idx_dec;
    logic       idx_inc;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       out_ld;
    logic [2:0] out_src;
    logic [2:0] out_status;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic idx_zero;
    logic idx_end;
    logic match;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### sv/obte_ram.sv
`default_nettype none
module obte_ram #(
  parameter int W = 97,
  parameter int D = 32
) (
  input  wire logic                               clk,
  input  wire logic                               we,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  wire logic [W-1:0]                       wdata,
  input  wire logic                               re,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic      [W-1:0]                       rdata
);

  logic [W-1:0] mem [D];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### sv/obte_dp.sv
`default_nettype none
module obte_dp #(
  parameter int CAPACITY = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [2:0]            in_kind,
  input  wire logic [31:0]           in_order_id,
  input  wire logic                  in_side,
  input  wire logic [30:0]           in_quantity,
  input  wire logic [31:0]           in_price,
  input  wire obte_pkg::cmd_t        cmd,
  output obte_pkg::sts_t             sts,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [2:0]                 out_status,
  output logic [31:0]                out_id,
  output logic                       out_side,
  output logic signed [31:0]         out_quantity,
  output logic [31:0]                out_price,
  output logic                       out_last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = $bits(obte_pkg::entry_t);

  logic [2:0]       kind_r;
  logic [31:0]      id_r;
  logic             side_r;
  logic [30:0]      qty_r;
  logic [31:0]      price_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [AW-1:0]    wr_addr;
  obte_pkg::entry_t wr_e, new_e, mod_e, rd_e, res_e;
  logic [EW-1:0]    rd_bits;
  logic signed [32:0] diff;

  obte_ram #(.W(EW), .D(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wr_addr),
    .wdata (wr_e),
    .re    (cmd.rd_en),
    .raddr (idx_r),
    .rdata (rd_bits)
  );

  assign rd_e = obte_pkg::entry_t'(rd_bits);

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      kind_r  <= in_kind;
      id_r    <= in_order_id;
      side_r  <= in_side;
      qty_r   <= in_quantity;
      price_r <= in_price;
    end
  end

  // New entry and updated entry
  always_comb begin
    new_e.id    = id_r;
    new_e.side  = side_r;
    new_e.qty   = $signed({1'b0, qty_r});
    new_e.price = price_r;
    diff  = $signed({rd_e.qty[31], rd_e.qty}) - $signed({2'b00, qty_r});
    mod_e = rd_e;
    if (kind_r == obte_pkg::KIND_REDUCE) begin
      // saturate on underflow only: the amount is never negative
      mod_e.qty = (diff[32] != diff[31]) ? obte_pkg::QTY_MIN : diff[31:0];
    end else begin
      mod_e.qty   = $signed({1'b0, qty_r});
      mod_e.price = price_r;
    end
  end

  // Select write address and data
  always_comb begin
    case (cmd.wr_sel)
      obte_pkg::WR_NEW: begin
        wr_addr = count_r[AW-1:0];
        wr_e    = new_e;
      end
      obte_pkg::WR_UPD: begin
        wr_addr = idx_r;
        wr_e    = mod_e;
      end
      default: begin
        wr_addr = idx_r - AW'(1);
        wr_e    = rd_e;
      end
    endcase
  end

  // Advance fill count and scan pointer
  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
    idx_nxt = idx_r;
    if (cmd.idx_top) begin
      idx_nxt = AW'(count_r - CW'(1));
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_r - AW'(1);
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Status back to the controller
  assign sts.count_zero = (count_r == '0);
  assign sts.count_full = (count_r == CW'(CAPACITY));
  assign sts.idx_zero   = (idx_r == '0);
  assign sts.idx_end    = ((CW'(idx_r) + CW'(1)) == count_r);
  assign sts.match      = (rd_e.id == id_r);
  assign sts.out_free   = !out_valid_r || !out_stall;

  // Pick result payload
  always_comb begin
    res_e = '0;
    case (cmd.out_src)
      obte_pkg::OSRC_NEW: res_e = new_e;
      obte_pkg::OSRC_RD:  res_e = rd_e;
      obte_pkg::OSRC_MOD: res_e = mod_e;
      obte_pkg::OSRC_ID:  res_e.id = id_r;
      default:            res_e = '0;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_status   <= cmd.out_status;
      out_id       <= res_e.id;
      out_side     <= res_e.side;
      out_quantity <= res_e.qty;
      out_price    <= res_e.price;
      out_last     <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### sv/obte_ctrl.sv
`default_nettype none
module obte_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [2:0]     in_kind,
  input  wire obte_pkg::sts_t sts,
  output obte_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_ADD   = 4'd2;
  localparam logic [3:0] S_FULL  = 4'd3;
  localparam logic [3:0] S_NF    = 4'd4;
  localparam logic [3:0] S_EMPTY = 4'd5;
  localparam logic [3:0] S_SRD   = 4'd6;
  localparam logic [3:0] S_SCMP  = 4'd7;
  localparam logic [3:0] S_UPD   = 4'd8;
  localparam logic [3:0] S_CXL   = 4'd9;
  localparam logic [3:0] S_CRD   = 4'd10;
  localparam logic [3:0] S_CWR   = 4'd11;
  localparam logic [3:0] S_DRD   = 4'd12;
  localparam logic [3:0] S_DOUT  = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [2:0] kind_r, kind_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          kind_nxt  = in_kind;
          state_nxt = S_DISP;
        end
      end
      // Route by kind
      S_DISP: begin
        case (kind_r)
          obte_pkg::KIND_ADD:
            state_nxt = sts.count_full ? S_FULL : S_ADD;
          obte_pkg::KIND_CANCEL, obte_pkg::KIND_REDUCE, obte_pkg::KIND_REPLACE: begin
            if (sts.count_zero) begin
              state_nxt = S_NF;
            end else begin
              cmd.idx_top = 1'b1;
              state_nxt   = S_SRD;
            end
          end
          obte_pkg::KIND_DUMP: begin
            if (sts.count_zero) begin
              state_nxt = S_EMPTY;
            end else begin
              cmd.idx_top = 1'b1;
              state_nxt   = S_DRD;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_ADD: begin
        if (sts.out_free) begin
          cmd.wr_en      = 1'b1;
          cmd.wr_sel     = obte_pkg::WR_NEW;
          cmd.cnt_inc    = 1'b1;
          cmd.out_ld     = 1'b1;
          cmd.out_src    = obte_pkg::OSRC_NEW;
          cmd.out_status = obte_pkg::ST_DONE;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_FULL: begin
        if (sts.out_free) begin
          cmd.out_ld     = 1'b1;
          cmd.out_src    = obte_pkg::OSRC_ID;
          cmd.out_status = obte_pkg::ST_FULL;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_NF: begin
        if (sts.out_free) begin
          cmd.out_ld     = 1'b1;
          cmd.out_src    = obte_pkg::OSRC_ID;
          cmd.out_status = obte_pkg::ST_NOT_FOUND;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.out_ld     = 1'b1;
          cmd.out_src    = obte_pkg::OSRC_ZERO;
          cmd.out_status = obte_pkg::ST_EMPTY;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      // Scan from newest to oldest for the id
      S_SRD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (sts.match) begin
          state_nxt = (kind_r == obte_pkg::KIND_CANCEL) ? S_CXL : S_UPD;
        end else if (sts.idx_zero) begin
          state_nxt = S_NF;
        end else begin
          cmd.idx_dec = 1'b1;
          state_nxt   = S_SRD;
        end
      end
      S_UPD: begin
        if (sts.out_free) begin
          cmd.wr_en      = 1'b1;
          cmd.wr_sel     = obte_pkg::WR_UPD;
          cmd.out_ld     = 1'b1;
          cmd.out_src    = obte_pkg::OSRC_MOD;
          cmd.out_status = obte_pkg::ST_DONE;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      // Report the removed entry, then close the gap
      S_CXL: begin
        if (sts.out_free) begin
          cmd.out_ld     = 1'b1;
          cmd.out_src    = obte_pkg::OSRC_RD;
          cmd.out_status = obte_pkg::ST_DONE;
          cmd.out_last   = 1'b1;
          if (sts.idx_end) begin
            cmd.cnt_dec = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_CRD;
          end
        end
      end
      S_CRD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CWR;
      end
      S_CWR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = obte_pkg::WR_SHIFT;
        if (sts.idx_end) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_CRD;
        end
      end
      // Dump newest first
      S_DRD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_DOUT;
      end
      S_DOUT: begin
        if (sts.out_free) begin
          cmd.out_ld     = 1'b1;
          cmd.out_src    = obte_pkg::OSRC_RD;
          cmd.out_status = obte_pkg::ST_DUMP;
          cmd.out_last   = sts.idx_zero;
          if (sts.idx_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_dec = 1'b1;
            state_nxt   = S_DRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= obte_pkg::KIND_ADD;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/order_book_table_engine_unit.sv
`default_nettype none
// Order table holding up to CAPACITY live orders in one RAM, kept in arrival
// order with a fill count, so the newest order sits at the top. Items are
// taken one at a time. Cancel, reduce and replace scan from the newest entry
// down, reading each entry visited through one RAM read port with registered
// data, then apply the change; cancel then moves each newer entry down one
// place. Dump reads the live orders, newest first, through the same read port.
module order_book_table_engine_unit #(
  parameter int CAPACITY = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [2:0]    in_kind,
  input  wire logic [31:0]   in_order_id,
  input  wire logic          in_side,
  input  wire logic [30:0]   in_quantity,
  input  wire logic [31:0]   in_price,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [2:0]         out_status,
  output logic [31:0]        out_id,
  output logic               out_side,
  output logic signed [31:0] out_quantity,
  output logic [31:0]        out_price,
  output logic               out_last
);

  obte_pkg::cmd_t cmd;
  obte_pkg::sts_t sts;

  obte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_kind  (in_kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  obte_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_kind      (in_kind),
    .in_order_id  (in_order_id),
    .in_side      (in_side),
    .in_quantity  (in_quantity),
    .in_price     (in_price),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_id       (out_id),
    .out_side     (out_side),
    .out_quantity (out_quantity),
    .out_price    (out_price),
    .out_last     (out_last)
  );

endmodule
`default_nettype wire

### tb/order_book_table_engine_unit_checker.sv
`timescale 1ns / 1ps
module order_book_table_engine_unit_checker #(
  parameter int CAPACITY = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_stall,
  input  wire logic [2:0]    in_kind,
  input  wire logic [31:0]   in_order_id,
  input  wire logic          in_side,
  input  wire logic [30:0]   in_quantity,
  input  wire logic [31:0]   in_price,
  input  wire logic          out_valid,
  input  wire logic          out_stall,
  input  wire logic [2:0]    out_status,
  input  wire logic [31:0]   out_id,
  input  wire logic          out_side,
  input  wire logic signed [31:0] out_quantity,
  input  wire logic [31:0]   out_price,
  input  wire logic          out_last,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        id;
    logic               side;
    logic signed [31:0] qty;
    logic [31:0]        price;
    logic               last;
  } reply_t;

  // Book model: index 0 is the newest order
  obte_pkg::entry_t book[$];
  reply_t reply_q[$];

  assign pending_count = reply_q.size();

  function automatic reply_t mk(logic [2:0] st, obte_pkg::entry_t e, logic lst);
    reply_t r;
    r.status = st;
    r.id = e.id;
    r.side = e.side;
    r.qty = e.qty;
    r.price = e.price;
    r.last = lst;
    return r;
  endfunction

  task automatic apply_order(logic [2:0] kind, logic [31:0] id, logic side,
                             logic [30:0] qty, logic [31:0] price);
    obte_pkg::entry_t e;
    obte_pkg::entry_t z;
    int hit;
    longint diff;
    z = '0;
    hit = -1;
    if (kind == obte_pkg::KIND_ADD) begin
      e.id = id;
      e.side = side;
      e.qty = {1'b0, qty};
      e.price = price;
      if (book.size() >= CAPACITY) begin
        z.id = id;
        reply_q.push_back(mk(obte_pkg::ST_FULL, z, 1'b1));
      end else begin
        book.push_front(e);
        reply_q.push_back(mk(obte_pkg::ST_DONE, e, 1'b1));
      end
    end else if (kind == obte_pkg::KIND_CANCEL || kind == obte_pkg::KIND_REDUCE ||
                 kind == obte_pkg::KIND_REPLACE) begin
      foreach (book[i]) if (hit < 0 && book[i].id == id) hit = i;
      if (hit < 0) begin
        z.id = id;
        reply_q.push_back(mk(obte_pkg::ST_NOT_FOUND, z, 1'b1));
      end else if (kind == obte_pkg::KIND_CANCEL) begin
        reply_q.push_back(mk(obte_pkg::ST_DONE, book[hit], 1'b1));
        book.delete(hit);
      end else begin
        if (kind == obte_pkg::KIND_REDUCE) begin
          diff = longint'(book[hit].qty) - longint'(qty);
          if (diff < longint'(obte_pkg::QTY_MIN)) diff = longint'(obte_pkg::QTY_MIN);
          book[hit].qty = diff[31:0];
        end else begin
          book[hit].qty = {1'b0, qty};
          book[hit].price = price;
        end
        reply_q.push_back(mk(obte_pkg::ST_DONE, book[hit], 1'b1));
      end
    end else if (kind == obte_pkg::KIND_DUMP) begin
      if (book.size() == 0) reply_q.push_back(mk(obte_pkg::ST_EMPTY, z, 1'b1));
      else foreach (book[i])
        reply_q.push_back(mk(obte_pkg::ST_DUMP, book[i], i == book.size() - 1));
    end
  endtask

  // Predict on accepted inputs, compare accepted results
  always @(posedge clk) begin
    reply_t got;
    reply_t exp;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_status, out_id, out_side, out_quantity, out_price, out_last};
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp = reply_q.pop_front();
          if (got !== exp) begin
            $display("%0t: mismatch expected st=%0d id=%h sd=%b q=%0d p=%h l=%b",
                     $time, exp.status, exp.id, exp.side, exp.qty, exp.price, exp.last);
            $display("%0t:            actual st=%0d id=%h sd=%b q=%0d p=%h l=%b",
                     $time, got.status, got.id, got.side, got.qty, got.price, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        apply_order(in_kind, in_order_id, in_side, in_quantity, in_price);
    end
  end

endmodule

### tb/order_book_table_engine_unit_tb.sv
`timescale 1ns / 1ps
module order_book_table_engine_unit_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_kind = obte_pkg::KIND_DUMP;
  logic [31:0] in_order_id = '0;
  logic in_side = 1'b0;
  logic [30:0] in_quantity = '0;
  logic [31:0] in_price = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic [31:0] out_id;
  logic out_side;
  logic signed [31:0] out_quantity;
  logic [31:0] out_price;
  logic out_last;
  int fail_count;
  int pending_count;
  bit calm = 1'b0;
  logic [31:0] id_pool[8];

  order_book_table_engine_unit dut (.*);
  order_book_table_engine_unit_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Random receiver stall, off during the calm stretch
  always @(negedge clk)
    out_stall <= !calm && ($urandom_range(99) < 34);

  // Present one item and hold it until accepted
  task automatic send(logic [2:0] k, logic [31:0] id, logic sd, logic [30:0] q,
                      logic [31:0] p);
    while (!calm && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_order_id <= id;
    in_side <= sd;
    in_quantity <= q;
    in_price <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int n;
    int r;
    logic [2:0] k;
    foreach (id_pool[i]) id_pool[i] = $urandom;
    id_pool[0] = '0;
    id_pool[1] = '1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Directed: empty dump, misses, extremes, saturation, only-entry cancel
    send(obte_pkg::KIND_DUMP, 0, 0, 0, 0);
    send(obte_pkg::KIND_CANCEL, 5, 0, 0, 0);
    send(obte_pkg::KIND_ADD, '1, 1, '1, '1);
    send(obte_pkg::KIND_CANCEL, '1, 0, 0, 0);
    send(obte_pkg::KIND_DUMP, 0, 0, 0, 0);
    send(obte_pkg::KIND_ADD, 0, 0, 0, 0);
    send(obte_pkg::KIND_REDUCE, 0, 0, '1, 0);
    send(obte_pkg::KIND_REDUCE, 0, 0, '1, 0);
    send(obte_pkg::KIND_REDUCE, 0, 0, 5, 0);
    send(obte_pkg::KIND_REPLACE, 0, 1, 31'h1234, 32'hdeadbeef);
    send(obte_pkg::KIND_ADD, 0, 1, 7, 9);
    send(obte_pkg::KIND_REDUCE, 0, 0, 1, 0);
    send(3'd5, 0, 0, 0, 0);
    send(3'd7, 0, 0, 0, 0);
    send(obte_pkg::KIND_REPLACE, 77, 0, 1, 1);
    // Fill past capacity, then dump the full book
    for (int i = 0; i < 33; i++)
      send(obte_pkg::KIND_ADD, 32'(i), i[0], 31'(i), 32'(i * 3));
    send(obte_pkg::KIND_DUMP, 0, 0, 0, 0);
    send(obte_pkg::KIND_CANCEL, 15, 0, 0, 0);
    send(obte_pkg::KIND_ADD, 100, 1, 2, 3);
    send(obte_pkg::KIND_DUMP, 0, 0, 0, 0);
    for (int i = 0; i < 33; i++) send(obte_pkg::KIND_CANCEL, 32'(i), 0, 0, 0);
    send(obte_pkg::KIND_CANCEL, 100, 0, 0, 0);
    // Random: ids mostly from a small pool so lookups hit
    for (n = 0; n < 374; n++) begin
      calm = (n >= 150 && n < 230);
      r = $urandom_range(99);
      k = r < 35 ? obte_pkg::KIND_ADD : r < 55 ? obte_pkg::KIND_CANCEL :
          r < 72 ? obte_pkg::KIND_REDUCE : r < 87 ? obte_pkg::KIND_REPLACE :
          r < 95 ? obte_pkg::KIND_DUMP : 3'($urandom_range(7, 5));
      send(k, $urandom_range(9) == 0 ? $urandom : id_pool[3'($urandom_range(7))],
           1'($urandom), $urandom_range(3) == 0 ? 31'h7fffffff : 31'($urandom),
           $urandom);
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
sv/obte_pkg.sv
sv/obte_ram.sv
sv/obte_dp.sv
sv/obte_ctrl.sv
sv/order_book_table_engine_unit.sv
tb/order_book_table_engine_unit_checker.sv
tb/order_book_table_engine_unit_tb.sv
